// ===== src/utdmt_pkg.sv =====
package utdmt_pkg;

   // Timestamps above this are in milliseconds.
   localparam logic [47:0] MsThreshold = 48'd100000000000;
   localparam logic [15:0] ZoneReset   = 16'd10800;

   localparam logic [31:0] SecPerDay   = 32'd86400;
   localparam logic [19:0] EpochShift  = 20'd719468;
   localparam logic [19:0] FourEras    = 20'd584388;
   localparam logic [19:0] FiveEras    = 20'd730485;
   localparam logic [17:0] DaysPerCent = 18'd36524;
   localparam logic [17:0] LastDoe     = 18'd146096;

   // Reciprocals for constant division, each exact over the range it serves.
   localparam logic [31:0] Div125Mult  = 32'd2199023256;   // shift 38, x < 2^31
   localparam logic [25:0] Div675Mult  = 26'd50903317;     // shift 35, x < 2^25
   localparam logic [12:0] Div225Mult  = 13'd4661;         // shift 20, x < 5400
   localparam logic [15:0] Div15Mult   = 16'd34953;        // shift 19, x < 21600
   localparam logic [14:0] Div365AMult = 15'd22983;        // shift 23, x < 36525
   localparam logic [17:0] Div365BMult = 18'd183860;       // shift 26, x < 146097
   localparam logic [10:0] Div153Mult  = 11'd1714;         // shift 18, x < 1828

   typedef struct packed {
      logic        valid;
      logic [31:0] seconds;
   } utdmt_sec_beat_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] days;
      logic [4:0]  hour;
      logic [5:0]  minute;
   } utdmt_day_beat_type;

   typedef struct packed {
      logic        valid;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [4:0]  hour;
      logic [5:0]  minute;
   } utdmt_date_beat_type;

   function automatic logic [23:0] div125(input logic [30:0] x);
      logic [62:0] p;
      p = 63'(x) * 63'(Div125Mult);
      return p[61:38];
   endfunction

   // Days before the first of each month of the March-based year.
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] r;
      unique case (mp)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd31;
         4'd2:    r = 9'd61;
         4'd3:    r = 9'd92;
         4'd4:    r = 9'd122;
         4'd5:    r = 9'd153;
         4'd6:    r = 9'd184;
         4'd7:    r = 9'd214;
         4'd8:    r = 9'd245;
         4'd9:    r = 9'd275;
         4'd10:   r = 9'd306;
         4'd11:   r = 9'd337;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== src/utdmt_channels.sv =====
interface utdmt_req_if;
   logic        valid;
   logic        ready;
   logic [47:0] timestamp_value;

   modport source (output valid, output timestamp_value, input ready);
   modport sink   (input valid, input timestamp_value, output ready);
endinterface

interface utdmt_rsp_if;
   logic       valid;
   logic       ready;
   logic [4:0] day_of_month;
   logic [3:0] month_number;
   logic [4:0] hour_of_day;
   logic [5:0] minute_of_hour;

   modport source (output valid, output day_of_month, output month_number,
                   output hour_of_day, output minute_of_hour, input ready);
   modport sink   (input valid, input day_of_month, input month_number,
                   input hour_of_day, input minute_of_hour, output ready);
endinterface

// ===== src/utdmt_sec_unit.sv =====
module utdmt_sec_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic [47:0]                   in_timestamp,
   input  logic [15:0]                   zone_offset,
   output utdmt_pkg::utdmt_sec_beat_type sec_beat
);

   logic        s1_valid_ff;
   logic [47:0] s1_ts_ff;

   logic        s2_valid_ff;
   logic        s2_ms_ff, s2_ms_in;
   logic [31:0] s2_low_ff, s2_low_in;
   logic [13:0] s2_q1_ff, s2_q1_in;
   logic [20:0] s2_hi_ff, s2_hi_in;
   logic [23:0] s2_lo_ff, s2_lo_in;
   logic [23:0] s2_quot;

   logic        s3_valid_ff;
   logic        s3_ms_ff;
   logic [31:0] s3_low_ff;
   logic [7:0]  s3_q1_ff;
   logic [30:0] s3_x_ff, s3_x_in;
   logic [20:0] s3_diff;

   logic        s4_valid_ff;
   logic [31:0] s4_sec_ff, s4_sec_in;

   logic        s5_valid_ff;
   logic [31:0] s5_sec_ff, s5_sec_in;

   // A millisecond count is divided by 8 and then by 125, the latter in two
   // long-division steps of 21 and 24 bits.
   always_comb begin
      s2_ms_in  = s1_ts_ff > utdmt_pkg::MsThreshold;
      s2_low_in = s1_ts_ff[31:0];
      s2_hi_in  = s1_ts_ff[47:27];
      s2_lo_in  = s1_ts_ff[26:3];
      s2_quot   = utdmt_pkg::div125({10'd0, s2_hi_in});
      s2_q1_in  = s2_quot[13:0];
   end

   always_comb begin
      s3_diff = s2_hi_ff - 21'(s2_q1_ff) * 21'd125;
      s3_x_in = {s3_diff[6:0], s2_lo_ff};
   end

   // Only the low 32 bits of the quotient are kept.
   always_comb begin
      s4_sec_in = s3_ms_ff ? {s3_q1_ff, utdmt_pkg::div125(s3_x_ff)} : s3_low_ff;
   end

   always_comb begin
      if (s4_sec_ff > 32'(zone_offset)) begin
         s5_sec_in = s4_sec_ff - 32'(zone_offset);
      end else begin
         s5_sec_in = s4_sec_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ts_ff  <= in_timestamp;
         s2_ms_ff  <= s2_ms_in;
         s2_low_ff <= s2_low_in;
         s2_q1_ff  <= s2_q1_in;
         s2_hi_ff  <= s2_hi_in;
         s2_lo_ff  <= s2_lo_in;
         s3_ms_ff  <= s2_ms_ff;
         s3_low_ff <= s2_low_ff;
         s3_q1_ff  <= s2_q1_ff[7:0];
         s3_x_ff   <= s3_x_in;
         s4_sec_ff <= s4_sec_in;
         s5_sec_ff <= s5_sec_in;
      end
   end

   assign sec_beat.valid   = s5_valid_ff;
   assign sec_beat.seconds = s5_sec_ff;

endmodule

// ===== src/utdmt_split.sv =====
module utdmt_split (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  utdmt_pkg::utdmt_sec_beat_type sec_beat,
   output utdmt_pkg::utdmt_day_beat_type day_beat
);

   logic        t1_valid_ff;
   logic [31:0] t1_sec_ff;
   logic [15:0] t1_days_ff, t1_days_in;
   logic [50:0] t1_prod;

   logic        t2_valid_ff;
   logic [15:0] t2_days_ff;
   logic [16:0] t2_rem_ff, t2_rem_in;
   logic [31:0] t2_diff;

   logic        t3_valid_ff;
   logic [15:0] t3_days_ff;
   logic [4:0]  t3_hour_ff, t3_hour_in;
   logic [10:0] t3_mins_ff, t3_mins_in;
   logic [25:0] t3_hprod;
   logic [29:0] t3_mprod;

   logic        t4_valid_ff;
   logic [15:0] t4_days_ff;
   logic [4:0]  t4_hour_ff;
   logic [5:0]  t4_minute_ff, t4_minute_in;
   logic [10:0] t4_diff;

   // 86400 is 128 times 675.
   always_comb begin
      t1_prod    = 51'(sec_beat.seconds[31:7]) * 51'(utdmt_pkg::Div675Mult);
      t1_days_in = t1_prod[50:35];
   end

   always_comb begin
      t2_diff   = t1_sec_ff - 32'(t1_days_ff) * utdmt_pkg::SecPerDay;
      t2_rem_in = t2_diff[16:0];
   end

   // Hours and whole minutes of the day are found side by side.
   always_comb begin
      t3_hprod   = 26'(t2_rem_ff[16:4]) * 26'(utdmt_pkg::Div225Mult);
      t3_mprod   = 30'(t2_rem_ff[16:2]) * 30'(utdmt_pkg::Div15Mult);
      t3_hour_in = t3_hprod[24:20];
      t3_mins_in = t3_mprod[29:19];
   end

   always_comb begin
      t4_diff      = t3_mins_ff - 11'(t3_hour_ff) * 11'd60;
      t4_minute_in = t4_diff[5:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_valid_ff <= 1'b0;
         t2_valid_ff <= 1'b0;
         t3_valid_ff <= 1'b0;
         t4_valid_ff <= 1'b0;
      end else if (advance) begin
         t1_valid_ff <= sec_beat.valid;
         t2_valid_ff <= t1_valid_ff;
         t3_valid_ff <= t2_valid_ff;
         t4_valid_ff <= t3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         t1_sec_ff    <= sec_beat.seconds;
         t1_days_ff   <= t1_days_in;
         t2_days_ff   <= t1_days_ff;
         t2_rem_ff    <= t2_rem_in;
         t3_days_ff   <= t2_days_ff;
         t3_hour_ff   <= t3_hour_in;
         t3_mins_ff   <= t3_mins_in;
         t4_days_ff   <= t3_days_ff;
         t4_hour_ff   <= t3_hour_ff;
         t4_minute_ff <= t4_minute_in;
      end
   end

   assign day_beat.valid  = t4_valid_ff;
   assign day_beat.days   = t4_days_ff;
   assign day_beat.hour   = t4_hour_ff;
   assign day_beat.minute = t4_minute_ff;

endmodule

// ===== src/utdmt_civil.sv =====
module utdmt_civil (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  utdmt_pkg::utdmt_day_beat_type  day_beat,
   output utdmt_pkg::utdmt_date_beat_type date_beat
);

   logic        c1_valid_ff;
   logic [17:0] c1_doe_ff, c1_doe_in;
   logic [4:0]  c1_hour_ff;
   logic [5:0]  c1_minute_ff;
   logic [19:0] c1_shifted;
   logic [19:0] c1_diff;

   logic        c2_valid_ff;
   logic [17:0] c2_doe_ff;
   logic [6:0]  c2_quad_ff, c2_quad_in;
   logic [2:0]  c2_cent_ff, c2_cent_in;
   logic        c2_last_ff, c2_last_in;
   logic [4:0]  c2_hour_ff;
   logic [5:0]  c2_minute_ff;
   logic [29:0] c2_prod;

   logic        c3_valid_ff;
   logic [17:0] c3_doe_ff;
   logic [8:0]  c3_yoe_ff, c3_yoe_in;
   logic [4:0]  c3_hour_ff;
   logic [5:0]  c3_minute_ff;
   logic [17:0] c3_span;
   logic [35:0] c3_prod;

   logic        c4_valid_ff;
   logic [8:0]  c4_doy_ff, c4_doy_in;
   logic [4:0]  c4_hour_ff;
   logic [5:0]  c4_minute_ff;
   logic [1:0]  c4_cent;
   logic [17:0] c4_diff;

   logic        c5_valid_ff;
   logic [8:0]  c5_doy_ff;
   logic [3:0]  c5_mp_ff, c5_mp_in;
   logic [4:0]  c5_hour_ff;
   logic [5:0]  c5_minute_ff;
   logic [21:0] c5_prod;

   logic [8:0]  c6_day;

   // The shifted day count always falls in the fifth or sixth era.
   always_comb begin
      c1_shifted = 20'(day_beat.days) + utdmt_pkg::EpochShift;
      if (c1_shifted >= utdmt_pkg::FiveEras) begin
         c1_diff = c1_shifted - utdmt_pkg::FiveEras;
      end else begin
         c1_diff = c1_shifted - utdmt_pkg::FourEras;
      end
      c1_doe_in = c1_diff[17:0];
   end

   always_comb begin
      c2_prod    = 30'(c1_doe_ff[17:2]) * 30'(utdmt_pkg::Div365AMult);
      c2_quad_in = c2_prod[29:23];
      c2_cent_in = 3'(c1_doe_ff >= utdmt_pkg::DaysPerCent)
                 + 3'(c1_doe_ff >= 18'd73048)
                 + 3'(c1_doe_ff >= 18'd109572)
                 + 3'(c1_doe_ff >= utdmt_pkg::LastDoe);
      c2_last_in = c1_doe_ff == utdmt_pkg::LastDoe;
   end

   always_comb begin
      c3_span   = c2_doe_ff - 18'(c2_quad_ff) + 18'(c2_cent_ff) - 18'(c2_last_ff);
      c3_prod   = 36'(c3_span) * 36'(utdmt_pkg::Div365BMult);
      c3_yoe_in = c3_prod[34:26];
   end

   always_comb begin
      c4_cent   = 2'(c3_yoe_ff >= 9'd100) + 2'(c3_yoe_ff >= 9'd200)
                + 2'(c3_yoe_ff >= 9'd300);
      c4_diff   = c3_doe_ff - (18'(c3_yoe_ff) * 18'd365 + 18'(c3_yoe_ff[8:2])
                - 18'(c4_cent));
      c4_doy_in = c4_diff[8:0];
   end

   always_comb begin
      c5_prod  = (22'(c4_doy_ff) * 22'd5 + 22'd2) * 22'(utdmt_pkg::Div153Mult);
      c5_mp_in = c5_prod[21:18];
   end

   // Months run from March, so the last two wrap into the next year.
   always_comb begin
      c6_day          = c5_doy_ff - utdmt_pkg::month_start(c5_mp_ff) + 9'd1;
      date_beat.valid = c5_valid_ff;
      date_beat.day   = c6_day[4:0];
      if (c5_mp_ff < 4'd10) begin
         date_beat.month = c5_mp_ff + 4'd3;
      end else begin
         date_beat.month = c5_mp_ff - 4'd9;
      end
      date_beat.hour   = c5_hour_ff;
      date_beat.minute = c5_minute_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_valid_ff <= 1'b0;
         c2_valid_ff <= 1'b0;
         c3_valid_ff <= 1'b0;
         c4_valid_ff <= 1'b0;
         c5_valid_ff <= 1'b0;
      end else if (advance) begin
         c1_valid_ff <= day_beat.valid;
         c2_valid_ff <= c1_valid_ff;
         c3_valid_ff <= c2_valid_ff;
         c4_valid_ff <= c3_valid_ff;
         c5_valid_ff <= c4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c1_doe_ff    <= c1_doe_in;
         c1_hour_ff   <= day_beat.hour;
         c1_minute_ff <= day_beat.minute;
         c2_doe_ff    <= c1_doe_ff;
         c2_quad_ff   <= c2_quad_in;
         c2_cent_ff   <= c2_cent_in;
         c2_last_ff   <= c2_last_in;
         c2_hour_ff   <= c1_hour_ff;
         c2_minute_ff <= c1_minute_ff;
         c3_doe_ff    <= c2_doe_ff;
         c3_yoe_ff    <= c3_yoe_in;
         c3_hour_ff   <= c2_hour_ff;
         c3_minute_ff <= c2_minute_ff;
         c4_doy_ff    <= c4_doy_in;
         c4_hour_ff   <= c3_hour_ff;
         c4_minute_ff <= c3_minute_ff;
         c5_doy_ff    <= c4_doy_ff;
         c5_mp_ff     <= c5_mp_in;
         c5_hour_ff   <= c4_hour_ff;
         c5_minute_ff <= c4_minute_ff;
      end
   end

endmodule

// ===== src/unix_time_to_day_month_time_unit.sv =====
// Converts a Unix timestamp to local day of month, month, hour and minute.
// The request channel carries one timestamp per beat; a value above
// 100000000000 is read as milliseconds. The response channel carries the
// day, month, hour and minute of that instant after the time-zone offset in
// the single configuration register has been taken off (only when the
// seconds exceed it). The register is written with csr_wr_en and
// csr_wr_data and should only change while no beat is in flight.
// The block is a fifteen-register pipeline, and one beat is accepted every
// cycle while the response side takes results. When the receiver stalls, the
// whole pipeline holds and req_chan.ready falls until the waiting result is
// taken, so nothing is lost or repeated. Reset empties the pipeline and the
// output register and sets the zone offset to 10800 seconds.
module unix_time_to_day_month_time_unit (
   input  logic        clock,
   input  logic        reset,
   utdmt_req_if.sink   req_chan,
   utdmt_rsp_if.source rsp_chan,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic                            advance;
   logic [15:0]                     zone_ff;
   utdmt_pkg::utdmt_sec_beat_type   sec_beat;
   utdmt_pkg::utdmt_day_beat_type   day_beat;
   utdmt_pkg::utdmt_date_beat_type  date_beat;

   logic       rsp_valid_ff;
   logic [4:0] rsp_day_ff;
   logic [3:0] rsp_month_ff;
   logic [4:0] rsp_hour_ff;
   logic [5:0] rsp_minute_ff;

   // Every stage moves on together unless a result waits unclaimed.
   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff <= utdmt_pkg::ZoneReset;
      end else if (csr_wr_en) begin
         zone_ff <= csr_wr_data;
      end
   end

   utdmt_sec_unit u_sec_unit (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (req_chan.valid),
      .in_timestamp (req_chan.timestamp_value),
      .zone_offset  (zone_ff),
      .sec_beat     (sec_beat)
   );

   utdmt_split u_split (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .sec_beat (sec_beat),
      .day_beat (day_beat)
   );

   utdmt_civil u_civil (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .day_beat  (day_beat),
      .date_beat (date_beat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= date_beat.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_day_ff    <= date_beat.day;
         rsp_month_ff  <= date_beat.month;
         rsp_hour_ff   <= date_beat.hour;
         rsp_minute_ff <= date_beat.minute;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.day_of_month   = rsp_day_ff;
   assign rsp_chan.month_number   = rsp_month_ff;
   assign rsp_chan.hour_of_day    = rsp_hour_ff;
   assign rsp_chan.minute_of_hour = rsp_minute_ff;

   a_result_lands : assert property (@(posedge clock) disable iff (reset)
      advance && date_beat.valid |=> rsp_valid_ff)
      else $error("finished beat did not reach the output register");

   a_month_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_month_ff >= 4'd1 && rsp_month_ff <= 4'd12))
      else $error("month out of range");

   a_day_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_day_ff >= 5'd1))
      else $error("day of month is zero");

   a_clock_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_hour_ff <= 5'd23 && rsp_minute_ff <= 6'd59))
      else $error("time of day out of range");

endmodule
